[src/datetime_text_to_epoch_defines.svh]
// Assertion macros shared by the date-time to epoch converter.
`ifndef DATETIME_TEXT_TO_EPOCH_DEFINES_SVH
`define DATETIME_TEXT_TO_EPOCH_DEFINES_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside of reset.
`define DTTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dtte assertion failed");
// The condition must never be seen at a clock edge outside of reset.
`define DTTE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("dtte forbidden condition seen");
`else
`define DTTE_ASSERT(lbl, prop)
`define DTTE_NEVER(lbl, cond)
`endif
`endif

[src/dtte_pkg.sv]
// Types, constants and tables of the date-time to epoch converter.
package dtte_pkg;

  // Characters of the literal form.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h54;

  // Depth of the record queue between the parser and the converter.
  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Width of the day count since 1970 and of the time of day in seconds.
  localparam int DAYS_W = 22;
  localparam int HMS_W  = 17;

  // Reciprocal of 100 for 14-bit operands: n / 100 == (n * 5243) >> 19.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;

  typedef enum logic [2:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOND
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_CHECK,
    BK_SECS
  } bk_state_e;

  // One parsed literal, as handed from the parser to the converter.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        form_ok;
  } rec_t;

  // Days before the first of the month in a common year.
  function automatic logic [8:0] month_start_f(input logic [3:0] mo);
    logic [8:0] r;
    unique case (mo)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of the month in a common year.
  function automatic logic [4:0] month_len_f(input logic [3:0] mo);
    logic [4:0] r;
    unique case (mo)
      4'd2:                       r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:         r = 5'd31;
      default:                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[src/dtte_front.sv]
// Character parser: checks the literal form and collects the field values.
module dtte_front import dtte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_code_i,
  input  logic       has_char_i,
  input  logic       last_i,
  output logic       push_o,
  output rec_t       rec_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  second_q, second_d;
  logic        err_q, err_d;
  logic        seen_q, seen_d;

  always_comb begin
    phase_e      ph;
    logic [2:0]  cnt;
    logic [13:0] yr;
    logic [6:0]  mo, dy, hr, mi, se;
    logic        err, seen, is_digit, sep_ok;
    logic [2:0]  maxd, mind;
    logic [3:0]  dig;

    ph   = phase_q;
    cnt  = cnt_q;
    yr   = year_q;
    mo   = month_q;
    dy   = day_q;
    hr   = hour_q;
    mi   = minute_q;
    se   = second_q;
    err  = err_q;
    seen = seen_q;

    is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
    dig      = 4'(char_code_i - CH_ZERO);
    maxd     = (phase_q == PH_YEAR) ? 3'd4 : 3'd2;
    mind     = (phase_q == PH_YEAR) ? 3'd4 : 3'd1;

    unique case (phase_q)
      PH_YEAR, PH_MONTH:   sep_ok = (char_code_i == CH_DASH);
      PH_DAY:              sep_ok = (char_code_i == CH_SPACE) || (char_code_i == CH_T);
      PH_HOUR, PH_MINUTE:  sep_ok = (char_code_i == CH_COLON);
      default:             sep_ok = 1'b0;
    endcase

    if (has_char_i) begin
      seen = 1'b1;
      if (!err_q) begin
        if (is_digit && (cnt_q < maxd)) begin
          cnt = 3'(cnt_q + 3'd1);
          unique case (phase_q)
            PH_YEAR:   yr = 14'(year_q * 14'd10 + 14'(dig));
            PH_MONTH:  mo = 7'(month_q * 7'd10 + 7'(dig));
            PH_DAY:    dy = 7'(day_q * 7'd10 + 7'(dig));
            PH_HOUR:   hr = 7'(hour_q * 7'd10 + 7'(dig));
            PH_MINUTE: mi = 7'(minute_q * 7'd10 + 7'(dig));
            default:   se = 7'(second_q * 7'd10 + 7'(dig));
          endcase
        end else if (cnt_q < mind) begin
          err = 1'b1;
        end else if (!sep_ok) begin
          err = 1'b1;
        end else begin
          cnt = 3'd0;
          unique case (phase_q)
            PH_YEAR:   ph = PH_MONTH;
            PH_MONTH:  ph = PH_DAY;
            PH_DAY:    ph = PH_HOUR;
            PH_HOUR:   ph = PH_MINUTE;
            default:   ph = PH_SECOND;
          endcase
        end
      end
    end

    rec_o.year    = yr;
    rec_o.month   = mo;
    rec_o.day     = dy;
    rec_o.hour    = hr;
    rec_o.minute  = mi;
    rec_o.second  = se;
    rec_o.form_ok = seen && !err && (cnt != 3'd0) &&
                    ((ph == PH_DAY) || (ph == PH_MINUTE) || (ph == PH_SECOND));
    push_o        = take_i && last_i;

    phase_d  = phase_q;
    cnt_d    = cnt_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    err_d    = err_q;
    seen_d   = seen_q;
    if (take_i) begin
      if (last_i) begin
        // The literal is complete: start over for the next one.
        phase_d  = PH_YEAR;
        cnt_d    = 3'd0;
        year_d   = 14'd0;
        month_d  = 7'd0;
        day_d    = 7'd0;
        hour_d   = 7'd0;
        minute_d = 7'd0;
        second_d = 7'd0;
        err_d    = 1'b0;
        seen_d   = 1'b0;
      end else begin
        phase_d  = ph;
        cnt_d    = cnt;
        year_d   = yr;
        month_d  = mo;
        day_d    = dy;
        hour_d   = hr;
        minute_d = mi;
        second_d = se;
        err_d    = err;
        seen_d   = seen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_YEAR;
      cnt_q    <= 3'd0;
      year_q   <= 14'd0;
      month_q  <= 7'd0;
      day_q    <= 7'd0;
      hour_q   <= 7'd0;
      minute_q <= 7'd0;
      second_q <= 7'd0;
      err_q    <= 1'b0;
      seen_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      err_q    <= err_d;
      seen_q   <= seen_d;
    end
  end

endmodule

[src/dtte_queue.sv]
// Short record queue that decouples the parser from the converter.
module dtte_queue import dtte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output rec_t pop_data_o,
  output logic empty_o
);

  rec_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == QCW'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : QAW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : QAW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = QCW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/dtte_back.sv]
// Converter: range checks a parsed literal and computes its epoch seconds.
module dtte_back import dtte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  rec_t        q_data_i,
  output logic        q_pop_o,
  output logic [37:0] epoch_seconds_o,
  output logic        ok_o,
  output logic        empty_o,
  input  logic        pop_i
);

  bk_state_e          state_q, state_d;
  rec_t               rec_q;
  logic [7:0]         q100_q;
  logic [DAYS_W-1:0]  days_q;
  logic [HMS_W-1:0]   hms_q;
  logic               good_q;
  logic               out_valid_q, out_valid_d;
  logic [37:0]        epoch_q;
  logic               ok_q;

  logic               cap_en, div_en, check_en, out_we;
  logic               slot_free;
  logic [13:0]        prev_year;
  logic [26:0]        div_prod;
  logic [6:0]         rem100;
  logic               is_leap;
  logic [3:0]         mo4;
  logic [5:0]         dim;
  logic               good_c;
  logic [DAYS_W-1:0]  days_c;
  logic [HMS_W-1:0]   hms_c;
  logic [38:0]        secs_c;

  assign slot_free = !out_valid_q || pop_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!q_empty_i) state_d = BK_DIV;
      BK_DIV:   state_d = BK_CHECK;
      BK_CHECK: state_d = BK_SECS;
      BK_SECS:  if (slot_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cap_en   = 1'b0;
    div_en   = 1'b0;
    check_en = 1'b0;
    out_we   = 1'b0;
    unique case (state_q)
      BK_IDLE:  cap_en   = !q_empty_i;
      BK_DIV:   div_en   = 1'b1;
      BK_CHECK: check_en = 1'b1;
      BK_SECS:  out_we   = slot_free;
      default:  ;
    endcase
  end

  assign q_pop_o = cap_en;

  // Quotient of (year - 1) by 100 through a reciprocal multiply.
  assign prev_year = 14'(rec_q.year - 14'd1);
  assign div_prod  = 27'(prev_year) * 27'(RECIP_100);

  // Leap rules, derived from (year - 1) / 100 and its remainder.
  assign rem100  = 7'(prev_year - 14'(q100_q) * 14'd100);
  assign is_leap = ((rec_q.year[1:0] == 2'd0) && (rem100 != 7'd99)) ||
                   ((rem100 == 7'd99) && (q100_q[1:0] == 2'd3));
  assign mo4     = rec_q.month[3:0];
  assign dim     = 6'(month_len_f(mo4)) + 6'((mo4 == 4'd2) && is_leap);

  always_comb begin
    logic month_ok;
    month_ok = (rec_q.month >= 7'd1) && (rec_q.month <= 7'd12);
    good_c = rec_q.form_ok &&
             (rec_q.year >= 14'd1970) && (rec_q.year <= 14'd9999) && month_ok &&
             (rec_q.day >= 7'd1) && (rec_q.day <= 7'(dim)) &&
             (rec_q.hour <= 7'd23) && (rec_q.minute <= 7'd59) &&
             (rec_q.second <= 7'd60);
  end

  assign days_c = DAYS_W'(14'(rec_q.year - 14'd1970)) * DAYS_W'(365) +
                  DAYS_W'(prev_year >> 2) - DAYS_W'(q100_q) + DAYS_W'(q100_q >> 2) -
                  DAYS_W'(477) + DAYS_W'(month_start_f(mo4)) +
                  DAYS_W'((mo4 > 4'd2) && is_leap) + DAYS_W'(rec_q.day) - DAYS_W'(1);
  assign hms_c  = HMS_W'(rec_q.hour) * HMS_W'(3600) + HMS_W'(rec_q.minute) * HMS_W'(60) +
                  HMS_W'(rec_q.second);
  assign secs_c = 39'(days_q) * 39'd86400 + 39'(hms_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_we) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      rec_q <= q_data_i;
    end
    if (div_en) begin
      q100_q <= div_prod[RECIP_SH +: 8];
    end
    if (check_en) begin
      days_q <= days_c;
      hms_q  <= hms_c;
      good_q <= good_c;
    end
    if (out_we) begin
      epoch_q <= good_q ? secs_c[37:0] : 38'd0;
      ok_q    <= good_q;
    end
  end

  assign epoch_seconds_o = epoch_q;
  assign ok_o            = ok_q;
  assign empty_o         = !out_valid_q;

endmodule

[src/datetime_text_to_epoch.sv]
// Top level of the date-time literal to UTC epoch seconds converter.
// One transaction per cycle is taken while full is low; full is set only by a full queue.
// A result is ready once the last character's record has passed the queue and the converter
// sequencer's idle, divide, check and seconds states; two parsed literals can queue ahead.
// Reset is asynchronous and active low; it clears the parser, queue pointers and valid flag.
`include "datetime_text_to_epoch_defines.svh"
module datetime_text_to_epoch import dtte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  input  logic        has_char_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [37:0] epoch_seconds_o,
  output logic        ok_o
);

  // The front parser works on each character as it arrives. It accepts a
  // transaction whenever the record queue has room, so a long literal streams
  // through at full rate while the converter finishes the previous one.
  logic take;
  logic q_push;
  rec_t q_push_data;
  logic q_full;
  logic q_pop;
  rec_t q_pop_data;
  logic q_empty;

  assign take = push && !q_full;
  assign full = q_full;

  dtte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_code_i (char_code_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .push_o      (q_push),
    .rec_o       (q_push_data)
  );

  // Each completed literal becomes one record in this queue, including
  // literals that already broke the form, so every last character yields
  // exactly one result.
  dtte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // The back converter takes a record, divides the year minus one by 100, checks the
  // ranges and counts days, then scales the day count to seconds. Its
  // result register is the output side of the block.
  dtte_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (q_pop_data),
    .q_pop_o         (q_pop),
    .epoch_seconds_o (epoch_seconds_o),
    .ok_o            (ok_o),
    .empty_o         (empty),
    .pop_i           (pop)
  );

  // A completed literal is only produced when the queue had room for it.
  `DTTE_NEVER(a_no_queue_overflow, q_push && q_full)
  // The converter never takes a record that is not there.
  `DTTE_NEVER(a_no_queue_underflow, q_pop && q_empty)
  // A rejected literal always reports zero seconds.
  `DTTE_ASSERT(a_invalid_is_zero, (!empty && !ok_o) |-> (epoch_seconds_o == 38'd0))
  // No valid result lies beyond the end of year 9999.
  `DTTE_ASSERT(a_epoch_bound, !empty |-> (epoch_seconds_o <= 38'd253402300800))

endmodule
